[sv/rdpq_pkg.sv]
// ============================================================================
// rdpq_pkg
// Shared types, constants and codes for the ring distance prefix query block.
// ============================================================================
`default_nettype none

package rdpq_pkg;

    // Sizing
    localparam int MAX_NODES   = 1024;
    localparam int WEIGHT_BITS = 32;
    localparam int SUM_W       = 48;
    localparam int NODE_W      = 10;
    localparam int CFG_W       = 11;
    localparam int DEPTH       = MAX_NODES + 1;
    localparam int ADDR_W      = $clog2(DEPTH);
    localparam int EXT_W       = SUM_W - WEIGHT_BITS;

    // Input kinds carried on tuser
    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // Shared adder operations
    typedef enum logic
    {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } alu_op_t;

    typedef struct packed
    {
        alu_op_t           op;
        logic [SUM_W-1:0]  a;
        logic [SUM_W-1:0]  b;
    } alu_req_t;

    typedef struct packed
    {
        logic [SUM_W-1:0]  res;
        logic              lt;    // signed a < b, valid for ALU_SUB
    } alu_rsp_t;

    typedef struct packed
    {
        logic                     mode;
        logic [WEIGHT_BITS-1:0]   weight_fwd;
        logic [WEIGHT_BITS-1:0]   weight_back;
        logic [NODE_W-1:0]        from_node;
        logic [NODE_W-1:0]        to_node;
    } item_t;

    typedef struct packed
    {
        logic [SUM_W-1:0]  distance;
        logic              flawed;
    } result_t;

    typedef struct packed
    {
        logic               we;
        logic [ADDR_W-1:0]  waddr;
        logic [SUM_W-1:0]   wdata;
        logic               re;
        logic [ADDR_W-1:0]  raddr0;
        logic [ADDR_W-1:0]  raddr1;
    } ram_req_t;

    typedef struct packed
    {
        logic [SUM_W-1:0]  rdata0;
        logic [SUM_W-1:0]  rdata1;
    } ram_rsp_t;

endpackage

`default_nettype wire

[sv/rdpq_ram.sv]
// ============================================================================
// rdpq_ram
// Prefix sum memory: one write port, two registered read ports. Entry zero
// always reads as zero and is never written.
// ============================================================================
`default_nettype none

module rdpq_ram
    import rdpq_pkg::*;
(
    input  wire logic      clk,
    input  wire ram_req_t  req,
    output ram_rsp_t       rsp
);

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rdata0_reg;
    logic [SUM_W-1:0] rdata1_reg;
    logic             zero0_reg;
    logic             zero1_reg;

    // Write one entry, read two, hold read data when idle
    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rdata0_reg <= mem[req.raddr0];
            rdata1_reg <= mem[req.raddr1];
            zero0_reg  <= (req.raddr0 == '0);
            zero1_reg  <= (req.raddr1 == '0);
        end
    end

    // Force entry zero to read as a cleared sum
    assign rsp.rdata0 = zero0_reg ? '0 : rdata0_reg;
    assign rsp.rdata1 = zero1_reg ? '0 : rdata1_reg;

endmodule

`default_nettype wire

[sv/rdpq_alu.sv]
// ============================================================================
// rdpq_alu
// Shared 48-bit add/subtract unit with a signed less-than flag.
// ============================================================================
`default_nettype none

module rdpq_alu
    import rdpq_pkg::*;
(
    input  wire alu_req_t  req,
    output alu_rsp_t       rsp
);

    logic [SUM_W:0] diff;

    // Subtract one bit wider so the sign of the true difference survives
    assign diff = {req.a[SUM_W-1], req.a} - {req.b[SUM_W-1], req.b};

    always_comb
    begin
        case (req.op)
            ALU_ADD: rsp.res = req.a + req.b;
            ALU_SUB: rsp.res = diff[SUM_W-1:0];
            default: rsp.res = '0;
        endcase
        rsp.lt = diff[SUM_W];
    end

endmodule

`default_nettype wire

[sv/rdpq_ctrl.sv]
// ============================================================================
// rdpq_ctrl
// Sequencer: runs loads and queries as steps on the shared adder, drives the
// prefix memories and keeps the running sums, load count and pair fault.
// ============================================================================
`default_nettype none

module rdpq_ctrl
    import rdpq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic [CFG_W-1:0]   ring_size,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire item_t              in_item,
    output logic                    res_valid,
    input  wire logic               res_ready,
    output result_t                 res,
    output alu_req_t                alu_req,
    input  wire alu_rsp_t           alu_rsp,
    output ram_req_t                ram_f_req,
    input  wire ram_rsp_t           ram_f_rsp,
    output ram_req_t                ram_b_req,
    input  wire ram_rsp_t           ram_b_rsp
);

    typedef enum logic [11:0]
    {
        S_IDLE  = 12'b0000_0000_0001,
        S_LD_F  = 12'b0000_0000_0010,
        S_LD_B  = 12'b0000_0000_0100,
        S_LD_P  = 12'b0000_0000_1000,
        S_Q_RD  = 12'b0000_0001_0000,
        S_Q_DF  = 12'b0000_0010_0000,
        S_Q_DB  = 12'b0000_0100_0000,
        S_Q_WF  = 12'b0000_1000_0000,
        S_Q_WB  = 12'b0001_0000_0000,
        S_Q_ALT = 12'b0010_0000_0000,
        S_Q_MIN = 12'b0100_0000_0000,
        S_DONE  = 12'b1000_0000_0000
    } state_t;

    // Control state
    state_t             state_reg,    state_next;
    logic [CFG_W-1:0]   load_cnt_reg, load_cnt_next;
    logic               fault_reg,    fault_next;
    logic [SUM_W-1:0]   sum_f_reg,    sum_f_next;
    logic [SUM_W-1:0]   sum_b_reg,    sum_b_next;

    // Working registers
    logic [SUM_W-1:0]   wa_reg,     wa_next;
    logic [SUM_W-1:0]   wb_reg,     wb_next;
    logic [ADDR_W-1:0]  l_reg,      l_next;
    logic [ADDR_W-1:0]  r_reg,      r_next;
    logic               wrap_reg,   wrap_next;
    logic               same_reg,   same_next;
    logic               flawed_reg, flawed_next;
    logic [SUM_W-1:0]   df_reg,     df_next;
    logic [SUM_W-1:0]   db_reg,     db_next;
    logic [SUM_W-1:0]   dist_reg,   dist_next;

    logic [ADDR_W-1:0]  from_ext;
    logic [ADDR_W-1:0]  to_ext;
    logic [ADDR_W-1:0]  from_clamp;
    logic [ADDR_W-1:0]  to_clamp;
    logic [ADDR_W-1:0]  last_node;
    logic [ADDR_W-1:0]  next_addr;

    // Clamp node numbers to the last node of the ring
    assign from_ext   = ADDR_W'(in_item.from_node);
    assign to_ext     = ADDR_W'(in_item.to_node);
    assign last_node  = ADDR_W'(ring_size - CFG_W'(1));
    assign from_clamp = (from_ext >= ADDR_W'(ring_size)) ? last_node : from_ext;
    assign to_clamp   = (to_ext >= ADDR_W'(ring_size)) ? last_node : to_ext;
    assign next_addr  = ADDR_W'(load_cnt_reg + CFG_W'(1));

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        fault_next    = fault_reg;
        sum_f_next    = sum_f_reg;
        sum_b_next    = sum_b_reg;
        wa_next       = wa_reg;
        wb_next       = wb_reg;
        l_next        = l_reg;
        r_next        = r_reg;
        wrap_next     = wrap_reg;
        same_next     = same_reg;
        flawed_next   = flawed_reg;
        df_next       = df_reg;
        db_next       = db_reg;
        dist_next     = dist_reg;

        in_ready      = 1'b0;
        res_valid     = 1'b0;
        alu_req.op    = ALU_ADD;
        alu_req.a     = '0;
        alu_req.b     = '0;
        ram_f_req     = '0;
        ram_b_req     = '0;

        case (state_reg)
            // Take an item; loads past the ring size are dropped
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (in_item.mode == MODE_QUERY)
                    begin
                        l_next     = from_clamp;
                        r_next     = to_clamp;
                        wrap_next  = (from_clamp > to_clamp);
                        same_next  = (from_clamp == to_clamp);
                        state_next = S_Q_RD;
                    end
                    else if (load_cnt_reg < ring_size)
                    begin
                        wa_next    = {{EXT_W{in_item.weight_fwd[WEIGHT_BITS-1]}},
                                      in_item.weight_fwd};
                        wb_next    = {{EXT_W{in_item.weight_back[WEIGHT_BITS-1]}},
                                      in_item.weight_back};
                        state_next = S_LD_F;
                    end
                end
            end

            // Advance the forward prefix and store it
            S_LD_F:
            begin
                alu_req.a       = sum_f_reg;
                alu_req.b       = wa_reg;
                sum_f_next      = alu_rsp.res;
                ram_f_req.we    = 1'b1;
                ram_f_req.waddr = next_addr;
                ram_f_req.wdata = alu_rsp.res;
                state_next      = S_LD_B;
            end

            // Advance the backward prefix and store it
            S_LD_B:
            begin
                alu_req.a       = sum_b_reg;
                alu_req.b       = wb_reg;
                sum_b_next      = alu_rsp.res;
                ram_b_req.we    = 1'b1;
                ram_b_req.waddr = next_addr;
                ram_b_req.wdata = alu_rsp.res;
                state_next      = S_LD_P;
            end

            // Check the pair sum sign and count the node
            S_LD_P:
            begin
                alu_req.a     = wa_reg;
                alu_req.b     = wb_reg;
                fault_next    = fault_reg | alu_rsp.res[SUM_W-1];
                load_cnt_next = load_cnt_reg + CFG_W'(1);
                state_next    = S_IDLE;
            end

            // Read prefixes at target and source
            S_Q_RD:
            begin
                ram_f_req.re     = 1'b1;
                ram_f_req.raddr0 = r_reg;
                ram_f_req.raddr1 = l_reg;
                ram_b_req.re     = 1'b1;
                ram_b_req.raddr0 = r_reg;
                ram_b_req.raddr1 = l_reg;
                state_next       = S_Q_DF;
            end

            S_Q_DF:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ram_f_rsp.rdata0;
                alu_req.b  = ram_f_rsp.rdata1;
                df_next    = alu_rsp.res;
                state_next = S_Q_DB;
            end

            // Finish the backward stretch and read both totals
            S_Q_DB:
            begin
                alu_req.op       = ALU_SUB;
                alu_req.a        = ram_b_rsp.rdata0;
                alu_req.b        = ram_b_rsp.rdata1;
                db_next          = alu_rsp.res;
                ram_f_req.re     = 1'b1;
                ram_f_req.raddr0 = ADDR_W'(ring_size);
                ram_f_req.raddr1 = ADDR_W'(ring_size);
                ram_b_req.re     = 1'b1;
                ram_b_req.raddr0 = ADDR_W'(ring_size);
                ram_b_req.raddr1 = ADDR_W'(ring_size);
                state_next       = S_Q_WF;
            end

            // Add the forward total when the stretch wraps
            S_Q_WF:
            begin
                alu_req.a   = df_reg;
                alu_req.b   = wrap_reg ? ram_f_rsp.rdata0 : '0;
                df_next     = alu_rsp.res;
                flawed_next = fault_reg | ram_f_rsp.rdata0[SUM_W-1]
                            | ram_b_rsp.rdata0[SUM_W-1];
                state_next  = S_Q_WB;
            end

            S_Q_WB:
            begin
                alu_req.a  = db_reg;
                alu_req.b  = wrap_reg ? ram_b_rsp.rdata0 : '0;
                db_next    = alu_rsp.res;
                state_next = S_Q_ALT;
            end

            // Cost the other way round: backward total less the stretch
            S_Q_ALT:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = ram_b_rsp.rdata0;
                alu_req.b  = db_reg;
                db_next    = alu_rsp.res;
                state_next = S_Q_MIN;
            end

            // Pick the smaller cost, or zero for a flawed ring or a same-node query
            S_Q_MIN:
            begin
                alu_req.op = ALU_SUB;
                alu_req.a  = db_reg;
                alu_req.b  = df_reg;
                if (flawed_reg || same_reg)
                begin
                    dist_next = '0;
                end
                else
                begin
                    dist_next = alu_rsp.lt ? db_reg : df_reg;
                end
                state_next = S_DONE;
            end

            // Hold the result until the output register takes it
            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign res.distance = dist_reg;
    assign res.flawed   = flawed_reg;

    // Control and ring state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            load_cnt_reg <= '0;
            fault_reg    <= 1'b0;
            sum_f_reg    <= '0;
            sum_b_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            fault_reg    <= fault_next;
            sum_f_reg    <= sum_f_next;
            sum_b_reg    <= sum_b_next;
        end
    end

    // Working registers
    always_ff @(posedge clk)
    begin
        wa_reg     <= wa_next;
        wb_reg     <= wb_next;
        l_reg      <= l_next;
        r_reg      <= r_next;
        wrap_reg   <= wrap_next;
        same_reg   <= same_next;
        flawed_reg <= flawed_next;
        df_reg     <= df_next;
        db_reg     <= db_next;
        dist_reg   <= dist_next;
    end

endmodule

`default_nettype wire

[sv/ring_distance_prefix_query.sv]
// ============================================================================
// ring_distance_prefix_query
// Loads forward and backward node weights of a ring into prefix sum memories
// and answers shortest-direction distance queries between two nodes.
// ============================================================================
// A load beat (tuser 0) updates both prefix memories and the pair check
// before the next beat can be accepted; a load beyond ring_size is dropped
// in the idle state. For a query beat (tuser 1) the next beat can be accepted
// in the cycle after the output register takes its result. Every prefix step,
// difference and cost compare runs one at a time on the single 48-bit adder,
// and queries wait on the registered reads of the two prefix memories. One
// beat is worked on at a time; a finished result waits in the output register
// while the next beat is taken. Queries must follow the loading of all
// ring_size nodes. A flawed ring returns distance 0 with tuser set.
`default_nettype none

module ring_distance_prefix_query
    import rdpq_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [CFG_W-1:0]   cfg_wdata,       // ring_size
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // weight_fwd[31:0], weight_back[63:32], from_node[73:64], to_node[83:74]
    input  wire logic [87:0]        s_axis_tdata,
    input  wire logic               s_axis_tuser,    // mode
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [SUM_W-1:0]        m_axis_tdata,    // distance[47:0]
    output logic                    m_axis_tuser     // flawed
);

    logic [CFG_W-1:0]   ring_size_reg;
    logic [CFG_W-1:0]   ring_size_next;
    item_t              in_item;
    result_t            res;
    logic               res_valid;
    logic               res_ready;
    alu_req_t           alu_req;
    alu_rsp_t           alu_rsp;
    ram_req_t           ram_f_req;
    ram_req_t           ram_b_req;
    ram_rsp_t           ram_f_rsp;
    ram_rsp_t           ram_b_rsp;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic [SUM_W-1:0]   out_dist_reg;
    logic               out_flawed_reg;

    // Clamp the ring size into one to the node limit
    always_comb
    begin
        ring_size_next = ring_size_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                ring_size_next = CFG_W'(1);
            end
            else if (cfg_wdata > CFG_W'(MAX_NODES))
            begin
                ring_size_next = CFG_W'(MAX_NODES);
            end
            else
            begin
                ring_size_next = cfg_wdata;
            end
        end
    end

    // Unpack the input beat
    assign in_item.mode        = s_axis_tuser;
    assign in_item.weight_fwd  = s_axis_tdata[31:0];
    assign in_item.weight_back = s_axis_tdata[63:32];
    assign in_item.from_node   = s_axis_tdata[73:64];
    assign in_item.to_node     = s_axis_tdata[83:74];

    rdpq_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ring_size (ring_size_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .alu_req   (alu_req),
        .alu_rsp   (alu_rsp),
        .ram_f_req (ram_f_req),
        .ram_f_rsp (ram_f_rsp),
        .ram_b_req (ram_b_req),
        .ram_b_rsp (ram_b_rsp)
    );

    rdpq_alu u_alu
    (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    rdpq_ram u_ram_fwd
    (
        .clk (clk),
        .req (ram_f_req),
        .rsp (ram_f_rsp)
    );

    rdpq_ram u_ram_back
    (
        .clk (clk),
        .req (ram_b_req),
        .rsp (ram_b_rsp)
    );

    // Output register: load when empty or draining
    assign res_ready = !out_valid_reg || m_axis_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ring_size_reg <= CFG_W'(MAX_NODES);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            ring_size_reg <= ring_size_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_dist_reg   <= res.distance;
            out_flawed_reg <= res.flawed;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_dist_reg;
    assign m_axis_tuser  = out_flawed_reg;

endmodule

`default_nettype wire

[sv/rdpq_check.sv]
// ============================================================================
// rdpq_check
// Port-level checks for the ring distance prefix query block, bound to the
// top level.
// ============================================================================
`default_nettype none

module rdpq_check
    import rdpq_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               s_axis_tvalid,
    input wire logic               s_axis_tready,
    input wire logic               s_axis_tuser,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [SUM_W-1:0]   m_axis_tdata,
    input wire logic               m_axis_tuser
);

    // Hold an output beat until it is taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped before it was taken");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // A query keeps the block busy for the next cycle
    a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == MODE_QUERY
            |=> !s_axis_tready)
        else $error("input taken right after a query");

    // A flawed ring reports zero distance
    a_flawed_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("flawed result with nonzero distance");

endmodule

bind ring_distance_prefix_query rdpq_check u_rdpq_check
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[sim/tb_ring_distance_prefix_query.sv]
// ============================================================================
// tb_ring_distance_prefix_query
// Self-checking bench: loads node weights, asks distance queries and checks each
// result beat against a typed answer or a local prefix sum model of the ring.
// ============================================================================
// A short directed table covers clamping of the ring size, loads past the end
// of the ring, node numbers past the end, same-node queries, a ring with a
// negative total and the weight extremes. Random sessions then grow and
// shrink the ring, load every new node and ask queries with some ignored
// loads mixed in. The last session fills the ring to its full size and sets
// the sticky pair fault on the final node.
`default_nettype none

module tb_ring_distance_prefix_query;
    import rdpq_pkg::*;

    localparam int RUN_LIMIT  = 3_000_000;
    localparam int SETTLE_CYC = 12;

    typedef enum logic
    {
        ROW_CFG  = 1'b0,
        ROW_BEAT = 1'b1
    } row_kind_t;

    typedef struct packed
    {
        row_kind_t          kind;
        logic [CFG_W-1:0]   ring_size;
        item_t              beat;
        logic               fixed_ok;
        result_t            fixed;
    } stim_row_t;

    // Directed table: ring size writes, loads and queries, with the answer
    // typed in only where it is obvious
    localparam stim_row_t DIRECTED_ROWS [0:20] = '{
        '{ROW_CFG,  11'd0, '{MODE_LOAD,  32'd0, 32'd0, 10'd0, 10'd0}, 1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_LOAD,  32'd5, 32'd7, 10'd0, 10'd0}, 1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_LOAD,  32'd9, 32'd9, 10'd0, 10'd0}, 1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd0, 10'd0}, 1'b1, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd1023, 10'd0},
          1'b1, '{48'd0, 1'b0}},
        '{ROW_CFG,  11'd2, '{MODE_LOAD,  32'd0, 32'd0, 10'd0, 10'd0}, 1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_LOAD,  32'hFFFF_FC18, 32'd1000, 10'd0, 10'd0},
          1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd0, 10'd1}, 1'b1, '{48'd0, 1'b1}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd1, 10'd1}, 1'b1, '{48'd0, 1'b1}},
        '{ROW_CFG,  11'd6, '{MODE_LOAD,  32'd0, 32'd0, 10'd0, 10'd0}, 1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_LOAD,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 10'd0, 10'd0},
          1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_LOAD,  32'hFFFF_FFFF, 32'd1, 10'd0, 10'd0},
          1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_LOAD,  32'd0, 32'd0, 10'd0, 10'd0}, 1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_LOAD,  32'd100, 32'hFFFF_FFCE, 10'd0, 10'd0},
          1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd0, 10'd5}, 1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd5, 10'd0}, 1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd2, 10'd1023},
          1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd1023, 10'd3},
          1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd3, 10'd3}, 1'b1, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_LOAD,  32'h8000_0000, 32'h8000_0000, 10'd0, 10'd0},
          1'b0, '{48'd0, 1'b0}},
        '{ROW_BEAT, 11'd0, '{MODE_QUERY, 32'd0, 32'd0, 10'd1, 10'd4}, 1'b0, '{48'd0, 1'b0}}
    };

    logic               clk           = 1'b0;
    logic               rst_n         = 1'b0;
    logic               cfg_we        = 1'b0;
    logic [CFG_W-1:0]   cfg_wdata     = '0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    logic [87:0]        s_axis_tdata  = '0;    // weight_fwd, weight_back, from, to
    logic               s_axis_tuser  = 1'b0;  // mode
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    logic [SUM_W-1:0]   m_axis_tdata;          // distance
    logic               m_axis_tuser;          // flawed

    // Local copy of the ring state
    logic [SUM_W-1:0]   fwd_sums  [0:MAX_NODES];
    logic [SUM_W-1:0]   back_sums [0:MAX_NODES];
    int                 nodes_loaded    = 0;
    int                 ring_nodes      = MAX_NODES;
    logic               pair_fault_seen = 1'b0;

    result_t            pending_answers [$];
    int                 mismatch_count = 0;
    int                 snd_idle = 13;
    int                 rcv_idle = 53;

    ring_distance_prefix_query i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(RUN_LIMIT);
        $display("status: fail");
        $finish;
    end

    // Advance the ring model by one beat; return 1 if the beat yields an answer
    function automatic bit ring_answer(input item_t it, output result_t ans);
        logic [SUM_W-1:0] wf;
        logic [SUM_W-1:0] wb;
        logic [SUM_W-1:0] pair;
        logic [SUM_W-1:0] tot_f;
        logic [SUM_W-1:0] tot_b;
        logic [SUM_W-1:0] span_f;
        logic [SUM_W-1:0] span_b;
        logic [SUM_W-1:0] other;
        int               src;
        int               dst;
        ans = '0;
        if (it.mode == MODE_LOAD)
        begin
            // Drop loads past the end of the ring
            if (nodes_loaded < ring_nodes)
            begin
                wf   = {{EXT_W{it.weight_fwd[WEIGHT_BITS-1]}}, it.weight_fwd};
                wb   = {{EXT_W{it.weight_back[WEIGHT_BITS-1]}}, it.weight_back};
                pair = wf + wb;
                if (pair[SUM_W-1])
                    pair_fault_seen = 1'b1;
                fwd_sums[nodes_loaded + 1]  = fwd_sums[nodes_loaded] + wf;
                back_sums[nodes_loaded + 1] = back_sums[nodes_loaded] + wb;
                nodes_loaded++;
            end
            return 1'b0;
        end
        // Clamp node numbers to the last node of the ring
        src = (it.from_node >= ring_nodes) ? ring_nodes - 1 : int'(it.from_node);
        dst = (it.to_node >= ring_nodes) ? ring_nodes - 1 : int'(it.to_node);
        tot_f = fwd_sums[ring_nodes];
        tot_b = back_sums[ring_nodes];
        ans.flawed = pair_fault_seen | tot_f[SUM_W-1] | tot_b[SUM_W-1];
        if (!ans.flawed && src != dst)
        begin
            if (src < dst)
            begin
                span_f = fwd_sums[dst] - fwd_sums[src];
                span_b = back_sums[dst] - back_sums[src];
            end
            else
            begin
                span_f = tot_f - fwd_sums[src] + fwd_sums[dst];
                span_b = tot_b - back_sums[src] + back_sums[dst];
            end
            other        = tot_b - span_b;
            ans.distance = ($signed(other) < $signed(span_f)) ? other : span_f;
        end
        return 1'b1;
    endfunction

    // Weights with a non-negative pair sum, mixing small, full-range and
    // near-maximum values
    function automatic void pick_weights(output logic [WEIGHT_BITS-1:0] fw,
                                         output logic [WEIGHT_BITS-1:0] bw);
        longint pair_sum;
        case ($urandom_range(3))
            0:
            begin
                fw = $urandom_range(3000) - 1000;
                bw = $urandom_range(3000) - 1000;
            end
            1:
            begin
                fw = $urandom;
                bw = $urandom;
            end
            2:
            begin
                fw = 32'h7FFF_FFFF - $urandom_range(15);
                bw = $urandom_range(65535);
            end
            default:
            begin
                fw = $urandom_range(1 << 20);
                bw = $urandom_range(1 << 20);
            end
        endcase
        pair_sum = longint'($signed(fw)) + longint'($signed(bw));
        if (pair_sum < 0)
        begin
            fw = ~fw;
            bw = ~bw;
        end
        pair_sum = longint'($signed(fw)) + longint'($signed(bw));
        if (pair_sum < 0)
        begin
            fw[WEIGHT_BITS-1] = 1'b0;
            bw                = '0;
        end
    endfunction

    function automatic item_t load_beat(input logic [WEIGHT_BITS-1:0] fw,
                                        input logic [WEIGHT_BITS-1:0] bw);
        item_t it;
        it.mode        = MODE_LOAD;
        it.weight_fwd  = fw;
        it.weight_back = bw;
        it.from_node   = NODE_W'($urandom_range(1023));
        it.to_node     = NODE_W'($urandom_range(1023));
        return it;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        mismatch_count++;
    endtask

    // Present one beat, hold it until accepted, then record its answer
    task automatic send_beat(input item_t it, input logic fixed_ok, input result_t fixed);
        result_t ans;
        while ($urandom_range(99) < snd_idle)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'd0, it.to_node, it.from_node, it.weight_back, it.weight_fwd};
        s_axis_tuser  <= it.mode;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (ring_answer(it, ans))
            pending_answers.push_back(fixed_ok ? fixed : ans);
    endtask

    // Drop valid, wait for every answer, then let the block settle
    task automatic wait_idle();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    task automatic write_ring_size(input logic [CFG_W-1:0] value);
        wait_idle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (value == 0)
            ring_nodes = 1;
        else if (value > MAX_NODES)
            ring_nodes = MAX_NODES;
        else
            ring_nodes = int'(value);
    endtask

    // Queries over the current ring, with some loads that the block must ignore
    task automatic ask_queries(input int count);
        item_t   it;
        result_t none;
        none = '0;
        repeat (count)
        begin
            it.mode        = MODE_QUERY;
            it.weight_fwd  = $urandom;
            it.weight_back = $urandom;
            case ($urandom_range(9))
                0, 1:
                begin
                    it.from_node = NODE_W'($urandom_range(1023));
                    it.to_node   = NODE_W'($urandom_range(1023));
                end
                2:
                begin
                    it.from_node = NODE_W'($urandom_range(ring_nodes - 1));
                    it.to_node   = it.from_node;
                end
                3:
                begin
                    it = load_beat($urandom, $urandom);
                end
                default:
                begin
                    it.from_node = NODE_W'($urandom_range(ring_nodes - 1));
                    it.to_node   = NODE_W'($urandom_range(ring_nodes - 1));
                end
            endcase
            send_beat(it, 1'b0, none);
        end
    endtask

    // Sender side: reset, directed table, then random sessions
    initial
    begin
        int                     i;
        int                     s;
        int                     target;
        logic [WEIGHT_BITS-1:0] fw;
        logic [WEIGHT_BITS-1:0] bw;
        result_t                none;
        none         = '0;
        fwd_sums[0]  = '0;
        back_sums[0] = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < $size(DIRECTED_ROWS); i++)
        begin
            if (DIRECTED_ROWS[i].kind == ROW_CFG)
                write_ring_size(DIRECTED_ROWS[i].ring_size);
            else
                send_beat(DIRECTED_ROWS[i].beat, DIRECTED_ROWS[i].fixed_ok,
                          DIRECTED_ROWS[i].fixed);
        end

        for (s = 0; s < 8; s++)
        begin
            if (s == 3)
            begin
                snd_idle = 53;
                rcv_idle = 13;
            end
            if (s == 6)
            begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            // Grow the ring, shrink it to at most the loaded count, or fill it
            if (s == 7)
                target = 2047;
            else if (s % 3 == 2)
                target = $urandom_range(nodes_loaded, 1);
            else
            begin
                target = nodes_loaded + $urandom_range(250, 20);
                if (target > MAX_NODES - 1)
                    target = MAX_NODES - 1;
            end
            write_ring_size(CFG_W'(target));
            while (nodes_loaded < ring_nodes)
            begin
                pick_weights(fw, bw);
                // The final node of the full ring sets the sticky pair fault
                if (s == 7 && nodes_loaded == MAX_NODES - 1)
                begin
                    fw = 32'h8000_0000;
                    bw = 32'h7FFF_FFFF;
                end
                send_beat(load_beat(fw, bw), 1'b0, none);
            end
            ask_queries(4);
        end
        write_ring_size(CFG_W'(MAX_NODES));
        ask_queries(10);
        write_ring_size(CFG_W'(1));
        ask_queries(5);

        wait_idle();
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver side: stall at random
    always @(negedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= rcv_idle);
    end

    // Check each result beat against the oldest recorded answer
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_answers.size() == 0)
                report_mismatch("result beat with no query outstanding");
            else
            begin
                want = pending_answers.pop_front();
                if (m_axis_tdata !== want.distance)
                    report_mismatch($sformatf("distance %0h, wanted %0h",
                                              m_axis_tdata, want.distance));
                if (m_axis_tuser !== want.flawed)
                    report_mismatch($sformatf("flawed %0b, wanted %0b",
                                              m_axis_tuser, want.flawed));
            end
        end
    end

endmodule

`default_nettype wire

[files.f]
sv/rdpq_pkg.sv
sv/rdpq_ram.sv
sv/rdpq_alu.sv
sv/rdpq_ctrl.sv
sv/ring_distance_prefix_query.sv
sv/rdpq_check.sv
sim/tb_ring_distance_prefix_query.sv
